>>> rtl/swah_pkg.sv
// ----------------------------------------------------------------------------
// swah_pkg
// Shared types, step codes and build-time coefficient table maths for the
// stereo auto-wah filter.
// ----------------------------------------------------------------------------
package swah_pkg;

    // Resonator coefficients, all Q3.20
    typedef struct packed {
        logic signed [23:0] gain;
        logic signed [23:0] fb1;
        logic signed [23:0] fb2;
    } coef_t;

    // Lane schedule step codes
    typedef logic [3:0] step_t;

    localparam step_t STEP_FB1  = 4'd0;
    localparam step_t STEP_FB2  = 4'd1;
    localparam step_t STEP_SUM  = 4'd2;
    localparam step_t STEP_W0   = 4'd3;
    localparam step_t STEP_GAIN = 4'd4;
    localparam step_t STEP_Y    = 4'd5;
    localparam step_t STEP_WET  = 4'd6;
    localparam step_t STEP_DRY  = 4'd7;
    localparam step_t STEP_MIX  = 4'd8;
    localparam step_t STEP_MAG  = 4'd9;
    localparam step_t STEP_DIV  = 4'd10;
    localparam step_t STEP_OUT  = 4'd11;
    localparam step_t STEP_LAST = STEP_OUT;

    // Sequencer to lane control
    typedef struct packed {
        logic  load;
        logic  run;
        step_t step;
    } lane_ctl_t;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_WET_MIX  = 2'd0;
    localparam cfg_index_t REG_LFO_STEP = 2'd1;

    localparam logic [8:0]  WET_FULL      = 9'd256;
    localparam logic [8:0]  WET_RESET     = 9'd128;
    localparam logic [14:0] LFO_STEP_RESET = 15'd594;

    localparam coef_t COEF_RESET = '{gain: 24'sd1048576, fb1: 24'sd0, fb2: 24'sd0};

    // Output scaling: divide by 1280 as a shift by 8 then a divide by 5.
    // Magnitudes at or above 5 * 2^23 saturate anyway, so clamp there first.
    localparam logic [25:0] MAG_CAP     = 26'd41943040;
    localparam logic [25:0] RECIP_FIVE  = 26'd53687092;
    localparam int          RECIP_SHIFT = 28;

    // Q30 constants for the table build
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;

    // Restoring divide, elaboration use only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin or cos of x (Q30 radians, first quadrant), Q30 result
    function automatic longint trig_series(input logic [63:0] x, input logic sine);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] den;
        longint      sum;
        x2   = (x * x) >> 30;
        term = sine ? x : Q30_ONE;
        sum  = longint'(term);
        for (int n = 1; n <= 9; n++) begin
            if (sine) begin
                den = 64'((2 * n) * (2 * n + 1));
            end else begin
                den = 64'((2 * n - 1) * (2 * n));
            end
            term = div_u64((term * x2) >> 30, den);
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return sum;
    endfunction

    // cos of a 32-bit fraction of a turn, Q30
    function automatic longint cos_turn(input logic [31:0] t);
        logic [63:0] x;
        longint      res;
        x = ({34'd0, t[29:0]} * PI_HALF_Q30) >> 30;
        case (t[31:30])
            2'd0:    res = trig_series(x, 1'b0);
            2'd1:    res = -trig_series(x, 1'b1);
            2'd2:    res = -trig_series(x, 1'b0);
            default: res = trig_series(x, 1'b1);
        endcase
        return res;
    endfunction

    // 2^y, y and result Q30
    function automatic logic [63:0] exp2_q30(input logic [63:0] y);
        logic [63:0] n;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        n    = y >> 30;
        z    = ((y & 64'h3FFF_FFFF) * LN2_Q30) >> 30;
        term = Q30_ONE;
        sum  = term;
        for (int i = 1; i <= 12; i++) begin
            term = div_u64((term * z) >> 30, 64'(i));
            sum  = sum + term;
        end
        if (n > 64'd7) begin
            n = 64'd7;
        end
        return sum << n;
    endfunction

    // Q30 to Q3.20: round half away from zero, saturate to 24 bits
    function automatic logic signed [23:0] q30_to_coef(input longint v);
        logic [63:0]        m;
        longint             r;
        logic signed [23:0] res;
        m = (v < 0) ? 64'(-v) : 64'(v);
        m = (m + 64'd512) >> 10;
        r = (v < 0) ? -longint'(m) : longint'(m);
        if (r > 64'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (r < -64'sd8388608) begin
            res = 24'sh800000;
        end else begin
            res = 24'(r);
        end
        return res;
    endfunction

    // One coefficient table entry
    function automatic coef_t coef_entry(input int unsigned k, input int unsigned depth,
                                         input int unsigned rate);
        logic [31:0] t;
        longint      s;
        longint      cv;
        longint      a1_30;
        longint      a2_30;
        logic [63:0] th;
        logic [63:0] g30;
        logic [63:0] f0q16;
        logic [63:0] eq;
        logic [63:0] ratio;
        logic [63:0] c30;
        logic [63:0] r30;
        logic [63:0] cmag;
        logic [63:0] pr;
        coef_t       e;
        t = 32'(div_u64({32'(k), 32'd0}, 64'(depth)));
        s = cos_turn(t - 32'h4000_0000) + longint'(Q30_ONE);
        if (s < 0) begin
            s = 0;
        end
        if (s > longint'(2 * Q30_ONE)) begin
            s = longint'(2 * Q30_ONE);
        end
        th    = 64'(s) >> 1;
        g30   = (exp2_q30(2 * th) + 64'd5) / 64'd10;
        f0q16 = (64'd450 * exp2_q30((th * 64'd23 + 64'd5) / 64'd10) + 64'd8192) >> 14;
        eq    = exp2_q30(64'd3 * Q30_ONE - 2 * th);
        ratio = div_u64(f0q16 << 30, eq);
        c30   = div_u64(ratio * PI_Q30, 64'(rate) << 16);
        r30   = (c30 >= Q30_ONE) ? 64'd0 : Q30_ONE - c30;
        cv    = cos_turn(32'(div_u64(f0q16 << 16, 64'(rate))));
        cmag  = (cv < 0) ? 64'(-cv) : 64'(cv);
        pr    = (r30 * cmag + (64'd1 << 28)) >> 29;
        a1_30 = (cv >= 0) ? -longint'(pr) : longint'(pr);
        a2_30 = longint'((r30 * r30 + (64'd1 << 29)) >> 30);
        e.gain = q30_to_coef(longint'(g30));
        e.fb1  = q30_to_coef(a1_30);
        e.fb2  = q30_to_coef(a2_30);
        return e;
    endfunction

endpackage

>>> rtl/swah_coef_rom.sv
// ----------------------------------------------------------------------------
// swah_coef_rom
// Resonator coefficient table indexed by LFO phase, built at elaboration,
// registered read.
// ----------------------------------------------------------------------------
module swah_coef_rom #(
    parameter int DEPTH   = 256,
    parameter int RATE_HZ = 44100,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic [AW-1:0]     rd_addr,
    output swah_pkg::coef_t   rd_data
);

    swah_pkg::coef_t rom_words [DEPTH];
    swah_pkg::coef_t rd_data_reg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        localparam swah_pkg::coef_t ENTRY = swah_pkg::coef_entry(k, DEPTH, RATE_HZ);
        assign rom_words[k] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= rom_words[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/swah_lane.sv
// ----------------------------------------------------------------------------
// swah_lane
// One channel of the auto-wah: direct-form-II resonator, wet/dry mix and
// output scaling, all through a single shared 27x32 multiplier.
// ----------------------------------------------------------------------------
module swah_lane (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  swah_pkg::lane_ctl_t     ctl,
    input  logic signed [23:0]      sample,
    input  swah_pkg::coef_t         coef,
    input  logic [8:0]              wet,
    input  logic [8:0]              dry,
    output logic signed [23:0]      result
);

    logic signed [23:0] x_reg;
    logic signed [31:0] d1_reg;
    logic signed [31:0] d2_reg;
    logic signed [31:0] w0_reg;
    logic signed [31:0] y_reg;
    logic signed [58:0] prod_reg;
    logic signed [58:0] acc_reg;
    logic [25:0]        v_reg;
    logic               neg_reg;
    logic signed [23:0] result_reg;

    logic signed [26:0] mult_a;
    logic signed [31:0] mult_b;
    logic signed [58:0] x_ext;
    logic [58:0]        mix_mag;
    logic [58:0]        mix_rnd;
    logic [25:0]        v_next;
    logic [23:0]        quo;
    logic signed [23:0] result_next;

    // Round half away from zero by 2^20, saturate to Q8.23
    function automatic logic signed [31:0] rsat32(input logic signed [58:0] v);
        logic [58:0]        m;
        logic [58:0]        r;
        logic signed [31:0] res;
        m = v[58] ? 59'(-v) : 59'(v);
        r = (m + 59'd524288) >> 20;
        if (v[58]) begin
            res = (r > 59'd2147483648) ? 32'sh8000_0000 : -$signed(r[31:0]);
        end else begin
            res = (r > 59'd2147483647) ? 32'sh7FFF_FFFF : $signed(r[31:0]);
        end
        return res;
    endfunction

    assign x_ext = {{15{x_reg[23]}}, x_reg, 20'd0};

    always_comb begin
        case (ctl.step)
            swah_pkg::STEP_FB1: begin
                mult_a = 27'(coef.fb1);
                mult_b = d1_reg;
            end
            swah_pkg::STEP_FB2: begin
                mult_a = 27'(coef.fb2);
                mult_b = d2_reg;
            end
            swah_pkg::STEP_GAIN: begin
                mult_a = 27'(coef.gain);
                mult_b = w0_reg;
            end
            swah_pkg::STEP_WET: begin
                mult_a = $signed({18'd0, wet});
                mult_b = y_reg;
            end
            swah_pkg::STEP_DRY: begin
                mult_a = $signed({18'd0, dry});
                mult_b = 32'(x_reg);
            end
            swah_pkg::STEP_DIV: begin
                mult_a = $signed({1'b0, v_reg});
                mult_b = $signed({6'd0, swah_pkg::RECIP_FIVE});
            end
            default: begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    // Output scaling: (|mix| + 640) >> 8, clamp, then divide by 5
    assign mix_mag = acc_reg[58] ? 59'(-acc_reg) : 59'(acc_reg);
    assign mix_rnd = (mix_mag + 59'd640) >> 8;
    assign v_next  = (mix_rnd > 59'(swah_pkg::MAG_CAP)) ? swah_pkg::MAG_CAP : mix_rnd[25:0];
    assign quo     = prod_reg[swah_pkg::RECIP_SHIFT +: 24];

    always_comb begin
        if (neg_reg) begin
            result_next = -$signed(quo);
        end else if (quo[23]) begin
            result_next = 24'sh7FFFFF;
        end else begin
            result_next = $signed(quo);
        end
    end

    // Delay words: shift once w0 is settled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else if (ctl.run && ctl.step == swah_pkg::STEP_GAIN) begin
            d2_reg <= d1_reg;
            d1_reg <= w0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= sample;
        end
        prod_reg <= mult_a * mult_b;
        if (ctl.run) begin
            case (ctl.step)
                swah_pkg::STEP_FB2: acc_reg <= x_ext - prod_reg;
                swah_pkg::STEP_SUM: acc_reg <= acc_reg - prod_reg;
                swah_pkg::STEP_W0:  w0_reg  <= rsat32(acc_reg);
                swah_pkg::STEP_Y:   y_reg   <= rsat32(prod_reg);
                swah_pkg::STEP_DRY: acc_reg <= prod_reg;
                swah_pkg::STEP_MIX: acc_reg <= acc_reg + prod_reg;
                swah_pkg::STEP_MAG: begin
                    v_reg   <= v_next;
                    neg_reg <= acc_reg[58];
                end
                swah_pkg::STEP_OUT: result_reg <= result_next;
                default: ;
            endcase
        end
    end

    assign result = result_reg;

endmodule

>>> rtl/stereo_auto_wah_filter.sv
// Flow: an accepted word goes through ST_COEF if buffer_start is set (to load the
//   coefficient ROM word), then ST_RUN, then ST_DONE, which loads the output word.
// Handshake: s_ready is high only in ST_IDLE, so one word at a time is in work; each
//   runs the 12-step lane schedule (six products per lane through one multiplier).
// Reset: synchronous, active-low aresetn clears the handshake, sequencer, LFO phase,
//   coefficients (gain one), delay words; config regs to defaults; no clearing pass.
// ----------------------------------------------------------------------------
// stereo_auto_wah_filter
// Stereo auto-wah: LFO-swept resonant band-pass on each channel with wet/dry
// mix. Two lanes run the channels side by side; an output register merges
// their results into one word.
// ----------------------------------------------------------------------------
module stereo_auto_wah_filter #(
    parameter int LFO_TABLE_DEPTH = 256,
    parameter int SAMPLE_RATE_HZ  = 44100
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [23:0]  s_left_sample,
    input  logic signed [23:0]  s_right_sample,
    input  logic                s_buffer_start,

    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [23:0]  m_left_out,
    output logic signed [23:0]  m_right_out,

    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [14:0]         cfg_wr_data
);

    localparam int AW  = $clog2(LFO_TABLE_DEPTH);
    localparam int KPW = 16 + AW + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COEF = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    swah_pkg::step_t      step_reg;
    swah_pkg::step_t      step_next;

    logic [8:0]           wet_mix_reg;
    logic [14:0]          lfo_step_reg;
    logic [15:0]          lfo_phase_reg;
    swah_pkg::coef_t      coef_reg;

    logic                 m_valid_reg;
    logic signed [23:0]   m_left_out_reg;
    logic signed [23:0]   m_right_out_reg;

    logic                 in_accept;
    logic                 load_out;
    logic [8:0]           wet_eff;
    logic [8:0]           dry_eff;
    logic [KPW-1:0]       phase_prod;
    logic [AW-1:0]        rom_addr;
    swah_pkg::coef_t      rom_data;
    swah_pkg::lane_ctl_t  lane_ctl;
    logic signed [23:0]   left_result;
    logic signed [23:0]   right_result;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;

    // Merge both lanes into the output register once it is free or being drained
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Clamp wet share to full scale; dry share is the remainder
    assign wet_eff = (wet_mix_reg > swah_pkg::WET_FULL) ? swah_pkg::WET_FULL : wet_mix_reg;
    assign dry_eff = swah_pkg::WET_FULL - wet_eff;

    // Table index: phase * depth / 65536; the ROM tracks the current phase every cycle
    assign phase_prod = KPW'(lfo_phase_reg) * KPW'(LFO_TABLE_DEPTH);
    assign rom_addr   = phase_prod[16 +: AW];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = swah_pkg::STEP_FB1;
                if (in_accept) begin
                    state_next = s_buffer_start ? ST_COEF : ST_RUN;
                end
            end
            ST_COEF: begin
                step_next  = swah_pkg::STEP_FB1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                step_next = step_reg + 4'd1;
                if (step_reg == swah_pkg::STEP_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = swah_pkg::STEP_FB1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= swah_pkg::STEP_FB1;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_mix_reg  <= swah_pkg::WET_RESET;
            lfo_step_reg <= swah_pkg::LFO_STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                swah_pkg::REG_WET_MIX:  wet_mix_reg  <= cfg_wr_data[8:0];
                swah_pkg::REG_LFO_STEP: lfo_step_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Coefficients and LFO: load at the current phase, then advance the phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg      <= swah_pkg::COEF_RESET;
            lfo_phase_reg <= '0;
        end else if (state_reg == ST_COEF) begin
            coef_reg      <= rom_data;
            lfo_phase_reg <= lfo_phase_reg + {1'b0, lfo_step_reg};
        end
    end

    swah_coef_rom #(
        .DEPTH   (LFO_TABLE_DEPTH),
        .RATE_HZ (SAMPLE_RATE_HZ)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    assign lane_ctl.load = in_accept;
    assign lane_ctl.run  = (state_reg == ST_RUN);
    assign lane_ctl.step = step_reg;

    swah_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_left_sample),
        .coef    (coef_reg),
        .wet     (wet_eff),
        .dry     (dry_eff),
        .result  (left_result)
    );

    swah_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_right_sample),
        .coef    (coef_reg),
        .wet     (wet_eff),
        .dry     (dry_eff),
        .result  (right_result)
    );

    // Output word register: hold until taken, refill straight after
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_left_out_reg  <= left_result;
            m_right_out_reg <= right_result;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_out_reg;
    assign m_right_out = m_right_out_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is still in work");

    a_coef_only_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COEF |-> $past(s_valid && s_ready && s_buffer_start))
        else $error("coefficient load without a buffer start word");

    a_phase_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_COEF |=> $stable(lfo_phase_reg))
        else $error("LFO phase moved outside a coefficient load");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN && step_reg == swah_pkg::STEP_LAST |=> state_reg == ST_DONE)
        else $error("lane schedule overran its last step");
`endif

endmodule

>>> test/tb_stereo_auto_wah_filter.sv
// ----------------------------------------------------------------------------
// tb_stereo_auto_wah_filter
// Self-checking bench for the stereo auto-wah. A bit-exact software copy of
// the filter predicts every output word: LFO phase, coefficient lookup on
// buffer starts, both resonators and the wet/dry mix. Input words go in with
// random gaps and output words are taken with random stalls.
// ----------------------------------------------------------------------------
module tb_stereo_auto_wah_filter;

    localparam int TABLE_DEPTH = 256;
    localparam int RATE_HZ     = 44100;

    // Stimulus sizes
    localparam int RANDOM_WORDS   = 1280;
    localparam int TAIL_WORDS     = 120;

    // Q30 constants for the coefficient maths
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] PI_RAD_Q30  = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] LN_TWO_Q30  = 64'd744261118;

    // Register indexes with nothing behind them
    localparam swah_pkg::cfg_index_t REG_SPARE_LO = 2'd2;
    localparam swah_pkg::cfg_index_t REG_SPARE_HI = 2'd3;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } stereo_word_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [23:0]       s_left_sample  = '0;
    logic signed [23:0]       s_right_sample = '0;
    logic                     s_buffer_start = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic signed [23:0]       m_left_out;
    logic signed [23:0]       m_right_out;
    logic                     cfg_wr_en      = 1'b0;
    swah_pkg::cfg_index_t     cfg_index      = swah_pkg::REG_WET_MIX;
    logic [14:0]              cfg_wr_data    = '0;

    // Shadow of the filter state, advanced by config writes and accepted input words
    logic [8:0]               wet_reg;
    logic [14:0]              step_reg;
    logic [15:0]              phase_acc;
    swah_pkg::coef_t          coefs;
    longint                   delay_line [2][2];

    stereo_word_t             filtered_due [$];
    int                       errors     = 0;
    int                       words_sent = 0;
    bit                       gap_on     = 1'b0;
    bit                       stall_on   = 1'b0;

    stereo_auto_wah_filter #(
        .LFO_TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_RATE_HZ  (RATE_HZ)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_buffer_start (s_buffer_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------------

    // Shift right, rounding half away from zero
    function automatic longint round_away(input longint v, input int sh);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Taylor series for sin or cos over the first quadrant, Q30 in and out
    function automatic longint quadrant_series(input logic [63:0] x, input bit sine);
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] div;
        longint      acc;
        x_sq = (x * x) >> 30;
        term = sine ? x : ONE_Q30;
        acc  = longint'(term);
        for (int n = 1; n <= 9; n++) begin
            div  = sine ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
            term = ((term * x_sq) >> 30) / div;
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    // Cosine of t / 2^32 of a full turn, Q30
    function automatic longint turn_cosine(input logic [31:0] t);
        logic [63:0] x;
        x = ({34'd0, t[29:0]} * HALF_PI_Q30) >> 30;
        case (t[31:30])
            2'd0:    return quadrant_series(x, 1'b0);
            2'd1:    return -quadrant_series(x, 1'b1);
            2'd2:    return -quadrant_series(x, 1'b0);
            default: return quadrant_series(x, 1'b1);
        endcase
    endfunction

    // 2 to the power y, Q30 in and out
    function automatic logic [63:0] power_of_two(input logic [63:0] y);
        logic [63:0] whole;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] acc;
        whole = y >> 30;
        z     = ((y & 64'h3FFF_FFFF) * LN_TWO_Q30) >> 30;
        term  = ONE_Q30;
        acc   = term;
        for (int i = 1; i <= 12; i++) begin
            term = ((term * z) >> 30) / 64'(i);
            acc  = acc + term;
        end
        if (whole > 64'd7) begin
            whole = 64'd7;
        end
        return acc << whole;
    endfunction

    function automatic logic signed [23:0] q30_to_q3_20(input longint v);
        return 24'(clamp_bits(round_away(v, 10), 24));
    endfunction

    // Gain and feedback pair for LFO table entry k
    function automatic swah_pkg::coef_t resonator_coefs(input logic [31:0] k);
        logic [31:0]     t;
        longint          s;
        longint          cv;
        longint          a1;
        longint          a2;
        logic [63:0]     th;
        logic [63:0]     g30;
        logic [63:0]     f0;
        logic [63:0]     q_fac;
        logic [63:0]     ratio;
        logic [63:0]     c30;
        logic [63:0]     r30;
        logic [63:0]     cmag;
        logic [63:0]     prod;
        swah_pkg::coef_t c;
        t = 32'((64'(k) << 32) / 64'(TABLE_DEPTH));
        s = turn_cosine(t - 32'h4000_0000) + longint'(ONE_Q30);
        if (s < 0) begin
            s = 0;
        end
        if (s > longint'(2 * ONE_Q30)) begin
            s = longint'(2 * ONE_Q30);
        end
        th    = 64'(s) >> 1;
        g30   = (power_of_two(2 * th) + 64'd5) / 64'd10;
        f0    = (64'd450 * power_of_two((th * 64'd23 + 64'd5) / 64'd10) + 64'd8192) >> 14;
        q_fac = power_of_two(64'd3 * ONE_Q30 - 2 * th);
        ratio = (f0 << 30) / q_fac;
        c30   = ratio * PI_RAD_Q30 / (64'(RATE_HZ) << 16);
        r30   = (c30 >= ONE_Q30) ? 64'd0 : ONE_Q30 - c30;
        cv    = turn_cosine(32'((f0 << 16) / 64'(RATE_HZ)));
        cmag  = (cv < 0) ? 64'(-cv) : 64'(cv);
        prod  = (r30 * cmag + (64'd1 << 28)) >> 29;
        a1    = (cv >= 0) ? -longint'(prod) : longint'(prod);
        a2    = longint'((r30 * r30 + (64'd1 << 29)) >> 30);
        c.gain = q30_to_q3_20(longint'(g30));
        c.fb1  = q30_to_q3_20(a1);
        c.fb2  = q30_to_q3_20(a2);
        return c;
    endfunction

    // One resonator plus wet/dry mix; advances that channel's delay words
    function automatic logic signed [23:0] resonate(input int ch, input longint x,
                                                    input longint wet);
        longint acc;
        longint w0;
        longint y;
        longint mix;
        longint o;
        acc = x * (64'sd1 <<< 20)
            - longint'(coefs.fb1) * delay_line[ch][0]
            - longint'(coefs.fb2) * delay_line[ch][1];
        w0  = clamp_bits(round_away(acc, 20), 32);
        delay_line[ch][1] = delay_line[ch][0];
        delay_line[ch][0] = w0;
        y   = clamp_bits(round_away(longint'(coefs.gain) * w0, 20), 32);
        mix = wet * y + (256 - wet) * x;
        o   = (mix < 0) ? -((640 - mix) / 1280) : (mix + 640) / 1280;
        return 24'(clamp_bits(o, 24));
    endfunction

    // Work out the output word for one accepted input word
    function automatic void predict_frame(input logic signed [23:0] l,
                                          input logic signed [23:0] r, input logic start);
        longint       wet;
        stereo_word_t w;
        wet = (wet_reg > swah_pkg::WET_FULL) ? 256 : longint'(wet_reg);
        if (start) begin
            coefs     = resonator_coefs((32'(phase_acc) * TABLE_DEPTH) >> 16);
            phase_acc = phase_acc + 16'(step_reg);
        end
        w.left  = resonate(0, longint'(l), wet);
        w.right = resonate(1, longint'(r), wet);
        filtered_due.push_back(w);
    endfunction

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 24'sh7F_FFFF;
            1:       return 24'sh80_0000;
            2:       return 24'($urandom_range(0, 255));
            3:       return 24'hFF_FFFF - 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offer one word, hold it until taken, then log its expected output.
    // Valid stays high afterwards; stop_sending drops it.
    task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                              input logic start);
        if (gap_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_left_sample  <= l;
        s_right_sample <= r;
        s_buffer_start <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_frame(l, r, start);
        words_sent++;
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_buffer(input int frames, input bit mark_start);
        for (int i = 0; i < frames; i++) begin
            send_frame(pick_sample(), pick_sample(), mark_start && i == 0);
        end
    endtask

    // Wait until every expected word has come out, then let the block settle
    task automatic wait_drained();
        while (filtered_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Enable stays high for back-to-back writes; end_writes drops it
    task automatic write_reg(input swah_pkg::cfg_index_t idx, input logic [14:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            swah_pkg::REG_WET_MIX:  wet_reg  = data[8:0];
            swah_pkg::REG_LFO_STEP: step_reg = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [14:0] wet_data, input logic [14:0] step_data);
        stop_sending();
        wait_drained();
        write_reg(swah_pkg::REG_WET_MIX, wet_data);
        write_reg(swah_pkg::REG_LFO_STEP, step_data);
        end_writes();
    endtask

    task automatic set_random_config();
        logic [14:0] wet_data;
        logic [14:0] step_data;
        case ($urandom_range(0, 5))
            0:       wet_data = 15'd0;
            1:       wet_data = 15'd256;
            2:       wet_data = 15'($urandom_range(257, 511));
            3:       wet_data = 15'($urandom_range(0, 32767));
            default: wet_data = 15'($urandom_range(0, 256));
        endcase
        case ($urandom_range(0, 5))
            0:       step_data = 15'd0;
            1:       step_data = 15'h7FFF;
            default: step_data = 15'($urandom_range(1, 32767));
        endcase
        set_config(wet_data, step_data);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset coefficients (unity gain, no feedback) until the first buffer start
    task automatic test_reset_defaults();
        send_frame(24'sh7F_FFFF, 24'sh80_0000, 1'b0);
        send_frame(24'sh80_0000, 24'sh7F_FFFF, 1'b1);
        send_frame(24'sd0, -24'sd1, 1'b0);
        send_frame(-24'sd1, 24'sd0, 1'b1);
    endtask

    // Full wet with the largest phase step: full-scale swings drive the
    // resonators into saturation and the phase wraps every other buffer
    task automatic test_full_wet_extremes();
        set_config(15'(swah_pkg::WET_FULL), 15'h7FFF);
        for (int i = 0; i < 8; i++) begin
            send_frame(i % 2 ? 24'sh80_0000 : 24'sh7F_FFFF,
                       i % 2 ? 24'sh7F_FFFF : 24'sh80_0000, i % 2 == 0);
        end
    endtask

    // Mix settings above full act as full; also the fully dry end
    task automatic test_wet_mix_range();
        set_config(15'h7FFF, 15'd0);
        send_frame(24'sh7F_FFFF, 24'sh80_0000, 1'b1);
        send_frame(24'sh40_0000, -24'sh40_0000, 1'b0);
        send_frame(24'sh7F_FFFF, 24'sh7F_FFFF, 1'b0);
        set_config(15'd0, 15'd1);
        send_frame(24'sh80_0000, 24'sh7F_FFFF, 1'b1);
        send_frame(24'sd1, -24'sd1, 1'b0);
        send_frame(24'sh12_3456, -24'sh65_4321, 1'b1);
    endtask

    // Writes to indexes beyond the last register must change nothing
    task automatic test_unused_index();
        stop_sending();
        wait_drained();
        write_reg(REG_SPARE_LO, 15'h7FFF);
        write_reg(REG_SPARE_HI, 15'h2AAA);
        end_writes();
        send_frame(24'sh55_5555, 24'shAA_AAAA, 1'b1);
        send_frame(24'shAA_AAAA, 24'sh55_5555, 1'b0);
        send_frame(24'sh7F_FFFF, 24'sh80_0000, 1'b1);
    endtask

    // Buffers of random length with random content, under random settings;
    // a few phases scatter start flags at random as noise
    task automatic test_random_buffers();
        int phase_end;
        bit noisy;
        phase_end = words_sent + RANDOM_WORDS;
        while (words_sent < phase_end) begin
            set_random_config();
            gap_on   = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            noisy    = $urandom_range(0, 7) == 0;
            repeat ($urandom_range(4, 12)) begin
                if (noisy) begin
                    send_frame(pick_sample(), pick_sample(), $urandom_range(0, 3) == 0);
                end else if ($urandom_range(0, 9) == 0) begin
                    send_buffer($urandom_range(17, 40), 1'b1);
                end else begin
                    // now and then carry on a buffer without a fresh start
                    send_buffer($urandom_range(1, 12), $urandom_range(0, 7) != 0);
                end
            end
        end
    endtask

    // Hold the sender mid-buffer until the pipeline is empty, then resume
    task automatic test_pause_mid_buffer();
        gap_on   = 1'b1;
        stall_on = 1'b1;
        send_buffer(6, 1'b1);
        stop_sending();
        wait_drained();
        send_buffer(6, 1'b0);
        send_buffer(4, 1'b1);
    endtask

    // Back-to-back words with the sink always ready
    task automatic test_steady_stream();
        int phase_end;
        set_random_config();
        gap_on    = 1'b0;
        stall_on  = 1'b0;
        phase_end = words_sent + TAIL_WORDS;
        while (words_sent < phase_end) begin
            send_buffer($urandom_range(4, 16), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sink side: random stall bursts while stall_on is set
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Compare each output word taken with the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (filtered_due.size() == 0) begin
                $display("%0t: output word with none due: left %0d right %0d",
                         $time, m_left_out, m_right_out);
                errors++;
            end else begin
                if (m_left_out !== filtered_due[0].left) begin
                    $display("%0t: left_out expected %0d, got %0d",
                             $time, filtered_due[0].left, m_left_out);
                    errors++;
                end
                if (m_right_out !== filtered_due[0].right) begin
                    $display("%0t: right_out expected %0d, got %0d",
                             $time, filtered_due[0].right, m_right_out);
                    errors++;
                end
                filtered_due.delete(0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        wet_reg   = swah_pkg::WET_RESET;
        step_reg  = swah_pkg::LFO_STEP_RESET;
        phase_acc = '0;
        coefs     = swah_pkg::COEF_RESET;
        for (int c = 0; c < 2; c++) begin
            delay_line[c][0] = 0;
            delay_line[c][1] = 0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_full_wet_extremes();
        test_wet_mix_range();
        test_unused_index();
        test_pause_mid_buffer();
        test_random_buffers();
        test_steady_stream();

        stop_sending();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> stereo_auto_wah_filter.f
rtl/swah_pkg.sv
rtl/swah_coef_rom.sv
rtl/swah_lane.sv
rtl/stereo_auto_wah_filter.sv
test/tb_stereo_auto_wah_filter.sv
